[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion wrappers used by the core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define SPR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define SPR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[design/spr_pkg.sv]
// ----------------------------------------------------------------------------
// Slotted page package
// Page geometry, field widths, request and status codes, result type.
// ----------------------------------------------------------------------------
package spr_pkg;

    localparam int PAGE_BYTES  = 4096;
    localparam int HDR_BYTES   = 16;
    localparam int ENTRY_BYTES = 4;

    localparam int ADDR_W   = $clog2(PAGE_BYTES);
    localparam int PTR_W    = $clog2(PAGE_BYTES + 1);
    localparam int SLOT_MAX = (PAGE_BYTES - HDR_BYTES) / ENTRY_BYTES;
    localparam int DIR_AW   = $clog2(SLOT_MAX);
    localparam int CNT_W    = $clog2(SLOT_MAX + 1);
    localparam int ENTRY_W  = 2 * PTR_W;

    localparam int REQ_W    = 2;
    localparam int LEN_W    = 13;
    localparam int BYTE_W   = 8;
    localparam int SLOT_W   = 10;
    localparam int BIDX_W   = 12;
    localparam int STAT_W   = 3;
    localparam int OFF_W    = 13;
    localparam int SIZE_W   = 13;
    localparam int TOTAL_W  = 10;
    localparam int FREE_W   = 12;
    localparam int CHK_W    = ((LEN_W > PTR_W) ? LEN_W : PTR_W) + 1;

    localparam logic [REQ_W-1:0] REQ_START = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DATA  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STAT_W-1:0] ST_BAD_SLOT  = 3'd2;
    localparam logic [STAT_W-1:0] ST_BAD_INDEX = 3'd3;
    localparam logic [STAT_W-1:0] ST_SEQ       = 3'd4;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [SLOT_W-1:0]  slot_id;
        logic [OFF_W-1:0]   rec_off;
        logic [SIZE_W-1:0]  record_size;
        logic [BYTE_W-1:0]  data_out;
        logic [TOTAL_W-1:0] slot_total;
        logic [FREE_W-1:0]  free_bytes;
    } t_result;

endpackage

[design/spr_req_if.sv]
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one request item.
// ----------------------------------------------------------------------------
interface spr_req_if;
    logic                        valid;
    logic                        ready;
    logic [spr_pkg::REQ_W-1:0]   req_type;
    logic [spr_pkg::LEN_W-1:0]   rec_len;
    logic [spr_pkg::BYTE_W-1:0]  data_byte;
    logic [spr_pkg::SLOT_W-1:0]  slot_index;
    logic [spr_pkg::BIDX_W-1:0]  byte_index;

    modport source (
        output valid, req_type, rec_len, data_byte, slot_index, byte_index,
        input  ready
    );
    modport sink (
        input  valid, req_type, rec_len, data_byte, slot_index, byte_index,
        output ready
    );
endinterface

[design/spr_res_if.sv]
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface spr_res_if;
    logic                         valid;
    logic                         ready;
    logic [spr_pkg::STAT_W-1:0]   status;
    logic [spr_pkg::SLOT_W-1:0]   slot_id;
    logic [spr_pkg::OFF_W-1:0]    rec_off;
    logic [spr_pkg::SIZE_W-1:0]   record_size;
    logic [spr_pkg::BYTE_W-1:0]   data_out;
    logic [spr_pkg::TOTAL_W-1:0]  slot_total;
    logic [spr_pkg::FREE_W-1:0]   free_bytes;

    modport source (
        output valid, status, slot_id, rec_off, record_size, data_out,
               slot_total, free_bytes,
        input  ready
    );
    modport sink (
        input  valid, status, slot_id, rec_off, record_size, data_out,
               slot_total, free_bytes,
        output ready
    );
endinterface

[design/spr_ram.sv]
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module spr_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

[design/spr_out_stage.sv]
// ----------------------------------------------------------------------------
// Result output stage
// Two-entry register queue in front of the result channel.
// ----------------------------------------------------------------------------
module spr_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  spr_pkg::t_result i_res,
    output logic             o_room,
    spr_res_if.source        o_res
);

    logic             r_head_valid;
    logic             r_skid_valid;
    logic             n_head_valid;
    logic             n_skid_valid;
    spr_pkg::t_result r_head;
    spr_pkg::t_result r_skid;
    spr_pkg::t_result n_head;
    spr_pkg::t_result n_skid;
    logic             pop;

    assign pop    = r_head_valid && o_res.ready;
    assign o_room = !r_skid_valid;

    always_comb begin
        n_head_valid = r_head_valid;
        n_skid_valid = r_skid_valid;
        n_head       = r_head;
        n_skid       = r_skid;
        if (!r_head_valid || pop) begin
            if (r_skid_valid) begin
                n_head       = r_skid;
                n_head_valid = 1'b1;
                n_skid       = i_res;
                n_skid_valid = i_push;
            end else begin
                n_head       = i_res;
                n_head_valid = i_push;
            end
        end else if (i_push) begin
            n_skid       = i_res;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_head_valid <= n_head_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head <= n_head;
        r_skid <= n_skid;
    end

    assign o_res.valid       = r_head_valid;
    assign o_res.status      = r_head.status;
    assign o_res.slot_id     = r_head.slot_id;
    assign o_res.rec_off     = r_head.rec_off;
    assign o_res.record_size = r_head.record_size;
    assign o_res.data_out    = r_head.data_out;
    assign o_res.slot_total  = r_head.slot_total;
    assign o_res.free_bytes  = r_head.free_bytes;

endmodule

[design/spr_core.sv]
// ----------------------------------------------------------------------------
// Slotted page core
// Page bookkeeping, request sequencer, directory and record memories.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spr_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    spr_req_if.sink          i_req,
    input  logic             i_room,
    output logic             o_push,
    output spr_pkg::t_result o_res
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIR  = 3'b010,
        S_DATA = 3'b100
    } t_state;

    t_state                        r_state, n_state;
    logic [spr_pkg::CNT_W-1:0]     r_count, n_count;
    logic [spr_pkg::PTR_W-1:0]     r_dir_end, n_dir_end;
    logic [spr_pkg::PTR_W-1:0]     r_ras, n_ras;
    logic [spr_pkg::PTR_W-1:0]     r_pending, n_pending;
    logic [spr_pkg::PTR_W-1:0]     r_wptr, n_wptr;
    logic                          r_active, n_active;
    logic [spr_pkg::PTR_W-1:0]     r_open_off, n_open_off;
    logic [spr_pkg::PTR_W-1:0]     r_open_len, n_open_len;
    logic [spr_pkg::SLOT_W-1:0]    r_slot, n_slot;
    logic [spr_pkg::BIDX_W-1:0]    r_bidx, n_bidx;
    logic [spr_pkg::PTR_W-1:0]     r_e_off, n_e_off;
    logic [spr_pkg::PTR_W-1:0]     r_e_len, n_e_len;

    logic                          accept;
    logic                          commit;
    logic [spr_pkg::PTR_W-1:0]     c_off;
    logic [spr_pkg::PTR_W-1:0]     c_len;
    logic [spr_pkg::PTR_W-1:0]     free_now;
    logic [spr_pkg::PTR_W-1:0]     start_off;
    logic [spr_pkg::PTR_W-1:0]     e_off;
    logic [spr_pkg::PTR_W-1:0]     e_len;

    logic                          dir_we;
    logic [spr_pkg::DIR_AW-1:0]    dir_waddr;
    logic [spr_pkg::ENTRY_W-1:0]   dir_wdata;
    logic                          dir_re;
    logic [spr_pkg::DIR_AW-1:0]    dir_raddr;
    logic [spr_pkg::ENTRY_W-1:0]   dir_rdata;
    logic                          dat_we;
    logic [spr_pkg::ADDR_W-1:0]    dat_waddr;
    logic [spr_pkg::BYTE_W-1:0]    dat_wdata;
    logic                          dat_re;
    logic [spr_pkg::ADDR_W-1:0]    dat_raddr;
    logic [spr_pkg::BYTE_W-1:0]    dat_rdata;

    assign i_req.ready = (r_state == S_IDLE) && i_room;
    assign accept      = i_req.valid && i_req.ready;
    assign free_now    = r_ras - r_dir_end;
    assign start_off   = r_ras - spr_pkg::PTR_W'(i_req.rec_len);
    assign e_off       = dir_rdata[spr_pkg::PTR_W-1:0];
    assign e_len       = dir_rdata[spr_pkg::ENTRY_W-1:spr_pkg::PTR_W];

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_dir_end  = r_dir_end;
        n_ras      = r_ras;
        n_pending  = r_pending;
        n_wptr     = r_wptr;
        n_active   = r_active;
        n_open_off = r_open_off;
        n_open_len = r_open_len;
        n_slot     = r_slot;
        n_bidx     = r_bidx;
        n_e_off    = r_e_off;
        n_e_len    = r_e_len;
        commit     = 1'b0;
        c_off      = r_open_off;
        c_len      = r_open_len;
        o_push     = 1'b0;
        o_res      = '0;
        dir_we     = 1'b0;
        dir_waddr  = spr_pkg::DIR_AW'(r_count);
        dir_wdata  = '0;
        dir_re     = 1'b0;
        dir_raddr  = spr_pkg::DIR_AW'(i_req.slot_index);
        dat_we     = 1'b0;
        dat_waddr  = spr_pkg::ADDR_W'(r_wptr);
        dat_wdata  = i_req.data_byte;
        dat_re     = 1'b0;
        dat_raddr  = spr_pkg::ADDR_W'(e_off + spr_pkg::PTR_W'(r_bidx));

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_req.req_type)
                        spr_pkg::REQ_START: begin
                            o_push = 1'b1;
                            if (r_active) begin
                                o_res.status = spr_pkg::ST_SEQ;
                            end else if ((spr_pkg::CHK_W'(i_req.rec_len)
                                          + spr_pkg::CHK_W'(spr_pkg::ENTRY_BYTES))
                                         > spr_pkg::CHK_W'(free_now)) begin
                                o_res.status = spr_pkg::ST_FULL;
                            end else begin
                                n_open_off          = start_off;
                                n_open_len          = spr_pkg::PTR_W'(i_req.rec_len);
                                n_wptr              = start_off;
                                n_pending           = spr_pkg::PTR_W'(i_req.rec_len);
                                n_active            = 1'b1;
                                c_off               = start_off;
                                c_len               = spr_pkg::PTR_W'(i_req.rec_len);
                                commit              = (i_req.rec_len == '0);
                                o_res.status        = spr_pkg::ST_OK;
                                o_res.slot_id       = spr_pkg::SLOT_W'(r_count);
                                o_res.rec_off       = spr_pkg::OFF_W'(start_off);
                                o_res.record_size   = i_req.rec_len;
                            end
                        end
                        spr_pkg::REQ_DATA: begin
                            o_push = 1'b1;
                            if (!r_active) begin
                                o_res.status = spr_pkg::ST_SEQ;
                            end else begin
                                dat_we              = 1'b1;
                                n_wptr              = r_wptr + spr_pkg::PTR_W'(1);
                                n_pending           = r_pending - spr_pkg::PTR_W'(1);
                                commit              = (r_pending == spr_pkg::PTR_W'(1));
                                o_res.status        = spr_pkg::ST_OK;
                                o_res.slot_id       = spr_pkg::SLOT_W'(r_count);
                                o_res.rec_off       = spr_pkg::OFF_W'(r_wptr);
                                o_res.data_out      = i_req.data_byte;
                            end
                        end
                        spr_pkg::REQ_READ: begin
                            if (int'(i_req.slot_index) >= int'(r_count)) begin
                                o_push       = 1'b1;
                                o_res.status = spr_pkg::ST_BAD_SLOT;
                            end else begin
                                dir_re  = 1'b1;
                                n_slot  = i_req.slot_index;
                                n_bidx  = i_req.byte_index;
                                n_state = S_DIR;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DIR: begin
                n_e_off = e_off;
                n_e_len = e_len;
                if (int'(r_bidx) >= int'(e_len)) begin
                    o_push              = 1'b1;
                    o_res.status        = spr_pkg::ST_BAD_INDEX;
                    o_res.slot_id       = r_slot;
                    o_res.rec_off       = spr_pkg::OFF_W'(e_off);
                    o_res.record_size   = spr_pkg::SIZE_W'(e_len);
                    n_state             = S_IDLE;
                end else begin
                    dat_re  = 1'b1;
                    n_state = S_DATA;
                end
            end
            S_DATA: begin
                o_push              = 1'b1;
                o_res.status        = spr_pkg::ST_OK;
                o_res.slot_id       = r_slot;
                o_res.rec_off       = spr_pkg::OFF_W'(r_e_off);
                o_res.record_size   = spr_pkg::SIZE_W'(r_e_len);
                o_res.data_out      = dat_rdata;
                n_state             = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (commit) begin
            dir_we    = 1'b1;
            dir_wdata = {c_len, c_off};
            n_count   = r_count + spr_pkg::CNT_W'(1);
            n_dir_end = r_dir_end + spr_pkg::PTR_W'(spr_pkg::ENTRY_BYTES);
            n_ras     = c_off;
            n_active  = 1'b0;
            n_pending = '0;
        end

        o_res.slot_total = spr_pkg::TOTAL_W'(n_count);
        o_res.free_bytes = spr_pkg::FREE_W'(n_ras - n_dir_end);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_dir_end <= spr_pkg::PTR_W'(spr_pkg::HDR_BYTES);
            r_ras     <= spr_pkg::PTR_W'(spr_pkg::PAGE_BYTES);
            r_pending <= '0;
            r_wptr    <= '0;
            r_active  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_dir_end <= n_dir_end;
            r_ras     <= n_ras;
            r_pending <= n_pending;
            r_wptr    <= n_wptr;
            r_active  <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        r_open_off <= n_open_off;
        r_open_len <= n_open_len;
        r_slot     <= n_slot;
        r_bidx     <= n_bidx;
        r_e_off    <= n_e_off;
        r_e_len    <= n_e_len;
    end

    spr_ram #(
        .DEPTH (spr_pkg::SLOT_MAX),
        .WIDTH (spr_pkg::ENTRY_W)
    ) u_dir_ram (
        .i_clk   (i_clk),
        .i_we    (dir_we),
        .i_waddr (dir_waddr),
        .i_wdata (dir_wdata),
        .i_re    (dir_re),
        .i_raddr (dir_raddr),
        .o_rdata (dir_rdata)
    );

    spr_ram #(
        .DEPTH (spr_pkg::PAGE_BYTES),
        .WIDTH (spr_pkg::BYTE_W)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (dat_we),
        .i_waddr (dat_waddr),
        .i_wdata (dat_wdata),
        .i_re    (dat_re),
        .i_raddr (dat_raddr),
        .o_rdata (dat_rdata)
    );

    `SPR_ASSERT(a_dir_end_tracks_count,
        r_dir_end == spr_pkg::PTR_W'(spr_pkg::HDR_BYTES + spr_pkg::ENTRY_BYTES * int'(r_count)),
        "directory end out of step with slot count")
    `SPR_ASSERT(a_free_nonneg, r_ras >= r_dir_end, "record area overlaps directory")
    `SPR_ASSERT(a_open_has_bytes, r_active |-> (r_pending != '0), "open insert with no bytes left")
    `SPR_ASSERT(a_room_while_busy, (r_state != S_IDLE) |-> i_room, "read in flight without room")

endmodule

[design/slotted_page_record_store.sv]
// ----------------------------------------------------------------------------
// Slotted page record store
// Insert items and a bad-slot read are answered on transfer; results register at the output.
// A read does a directory read, then a byte RAM read; a bad index stops after the first.
// One item in flight; inserts go 1 item/cycle while the output stage has room.
// Up to two results queue at the output while the next item is taken.
// Synchronous reset: empty page, no open insert; page RAM is not cleared.
// ----------------------------------------------------------------------------
module slotted_page_record_store (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spr_req_if.sink   i_req,
    spr_res_if.source o_res
);

    logic             room;
    logic             push;
    spr_pkg::t_result res;

    spr_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_room  (room),
        .o_push  (push),
        .o_res   (res)
    );

    spr_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res   (res),
        .o_room  (room),
        .o_res   (o_res)
    );

endmodule

[test/slotted_page_record_store_tb.sv]
// ----------------------------------------------------------------------------
// Slotted page record store testbench
// Drives request transfers from a queue of pending requests and checks every
// result transfer, field by field, against a page model kept in the bench.
// A short directed part is followed by random insert sequences, reads and
// noise, a fill that leaves the page exactly full, and a tail on the full page.
// Both channels idle in random bursts, except in the last part of the run.
// ----------------------------------------------------------------------------
module slotted_page_record_store_tb;

    localparam logic [spr_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int RAND_ITEMS     = 900;
    localparam int TAIL_ITEMS     = 150;
    localparam int QUIET_ITEMS    = 200;
    localparam int END_CYCLES     = 16;
    localparam int WATCHDOG_LIMIT = 1000;

    typedef struct packed {
        logic [spr_pkg::REQ_W-1:0]  req_type;
        logic [spr_pkg::LEN_W-1:0]  rec_len;
        logic [spr_pkg::BYTE_W-1:0] data_byte;
        logic [spr_pkg::SLOT_W-1:0] slot_index;
        logic [spr_pkg::BIDX_W-1:0] byte_index;
    } t_request;

    logic i_clk;
    logic i_rst_n;

    spr_req_if req_ch ();
    spr_res_if res_ch ();

    slotted_page_record_store u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    t_request         request_q[$];
    spr_pkg::t_result reply_q[$];
    int               error_count = 0;
    int               gap_left    = 0;
    int               hold_left   = 0;
    int               idle_cycles = 0;

    // page model
    logic [7:0]                 page_mem [spr_pkg::PAGE_BYTES];
    logic [10:0]                slot_cnt;
    logic [spr_pkg::PTR_W-1:0]  dir_end;
    logic [spr_pkg::PTR_W-1:0]  area_start;
    logic [spr_pkg::LEN_W-1:0]  bytes_left;
    logic [16:0]                wr_ptr;
    logic                       ins_open;
    logic [spr_pkg::PTR_W-1:0]  open_off;
    logic [spr_pkg::LEN_W-1:0]  open_len;

    // shadow used while building the stimulus
    int g_free  = spr_pkg::PAGE_BYTES - spr_pkg::HDR_BYTES;
    bit g_open  = 0;
    int g_left  = 0;
    int g_len   = 0;
    int g_count = 0;
    int g_lens[$];

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n              = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.req_type      = '0;
        req_ch.rec_len       = '0;
        req_ch.data_byte     = '0;
        req_ch.slot_index    = '0;
        req_ch.byte_index    = '0;
        res_ch.ready         = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_error($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    // ------------------------------------------------------------------ model
    task automatic page_put16(input int a, input logic [15:0] v);
        page_mem[a % spr_pkg::PAGE_BYTES]       = v[7:0];
        page_mem[(a + 1) % spr_pkg::PAGE_BYTES] = v[15:8];
    endtask

    function automatic int page_get16(input int a);
        return int'({page_mem[(a + 1) % spr_pkg::PAGE_BYTES],
                     page_mem[a % spr_pkg::PAGE_BYTES]});
    endfunction

    function automatic spr_pkg::t_result page_reply(input logic [spr_pkg::STAT_W-1:0] st,
                                                    input int slot, input int off,
                                                    input int size, input int data);
        spr_pkg::t_result r;
        int               free_now;
        free_now        = int'(area_start) - int'(dir_end);
        r.status        = st;
        r.slot_id       = spr_pkg::SLOT_W'(slot);
        r.rec_off       = spr_pkg::OFF_W'(off);
        r.record_size   = spr_pkg::SIZE_W'(size);
        r.data_out      = spr_pkg::BYTE_W'(data);
        r.slot_total    = spr_pkg::TOTAL_W'(slot_cnt);
        r.free_bytes    = spr_pkg::FREE_W'(free_now);
        return r;
    endfunction

    task automatic page_commit();
        int e;
        e = spr_pkg::HDR_BYTES + int'(slot_cnt) * spr_pkg::ENTRY_BYTES;
        page_put16(e, 16'(open_off));
        page_put16(e + 2, 16'(open_len));
        slot_cnt   = slot_cnt + 11'd1;
        dir_end    = spr_pkg::PTR_W'(e + spr_pkg::ENTRY_BYTES);
        area_start = open_off;
        ins_open   = 1'b0;
        bytes_left = '0;
    endtask

    task automatic page_apply(input t_request rq);
        spr_pkg::t_result r;
        bit               has;
        int               s, off, size, a, e, free_now;
        has = 1'b1;
        case (rq.req_type)
            spr_pkg::REQ_START: begin
                free_now = int'(area_start) - int'(dir_end);
                if (ins_open) begin
                    r = page_reply(spr_pkg::ST_SEQ, 0, 0, 0, 0);
                end else if (int'(rq.rec_len) + spr_pkg::ENTRY_BYTES > free_now) begin
                    r = page_reply(spr_pkg::ST_FULL, 0, 0, 0, 0);
                end else begin
                    s          = int'(slot_cnt);
                    off        = int'(area_start) - int'(rq.rec_len);
                    open_off   = spr_pkg::PTR_W'(off);
                    open_len   = rq.rec_len;
                    wr_ptr     = 17'(off);
                    bytes_left = rq.rec_len;
                    ins_open   = 1'b1;
                    if (rq.rec_len == '0)
                        page_commit();
                    r = page_reply(spr_pkg::ST_OK, s, off, int'(rq.rec_len), 0);
                end
            end
            spr_pkg::REQ_DATA: begin
                if (!ins_open) begin
                    r = page_reply(spr_pkg::ST_SEQ, 0, 0, 0, 0);
                end else begin
                    s          = int'(slot_cnt);
                    a          = int'(wr_ptr);
                    page_mem[a % spr_pkg::PAGE_BYTES] = rq.data_byte;
                    wr_ptr     = wr_ptr + 17'd1;
                    bytes_left = bytes_left - spr_pkg::LEN_W'(1);
                    if (bytes_left == '0)
                        page_commit();
                    r = page_reply(spr_pkg::ST_OK, s, a, 0, int'(rq.data_byte));
                end
            end
            spr_pkg::REQ_READ: begin
                if (int'(rq.slot_index) >= int'(slot_cnt)) begin
                    r = page_reply(spr_pkg::ST_BAD_SLOT, 0, 0, 0, 0);
                end else begin
                    e    = spr_pkg::HDR_BYTES + int'(rq.slot_index) * spr_pkg::ENTRY_BYTES;
                    off  = page_get16(e);
                    size = page_get16(e + 2);
                    if (int'(rq.byte_index) >= size)
                        r = page_reply(spr_pkg::ST_BAD_INDEX, int'(rq.slot_index), off,
                                       size, 0);
                    else
                        r = page_reply(spr_pkg::ST_OK, int'(rq.slot_index), off, size,
                                       int'(page_mem[(off + int'(rq.byte_index))
                                                     % spr_pkg::PAGE_BYTES]));
                end
            end
            default: has = 1'b0;
        endcase
        if (has)
            reply_q.insert(reply_q.size(), r);
    endtask

    initial begin
        foreach (page_mem[i])
            page_mem[i] = 8'h00;
        slot_cnt   = '0;
        dir_end    = spr_pkg::PTR_W'(spr_pkg::HDR_BYTES);
        area_start = spr_pkg::PTR_W'(spr_pkg::PAGE_BYTES);
        bytes_left = '0;
        wr_ptr     = '0;
        ins_open   = 1'b0;
        open_off   = '0;
        open_len   = '0;
    end

    // --------------------------------------------------------------- stimulus
    task automatic push_req(input logic [spr_pkg::REQ_W-1:0] kind, input int len,
                            input int dbyte, input int slot, input int bidx);
        t_request rq;
        rq.req_type      = kind;
        rq.rec_len       = spr_pkg::LEN_W'(len);
        rq.data_byte     = spr_pkg::BYTE_W'(dbyte);
        rq.slot_index    = spr_pkg::SLOT_W'(slot);
        rq.byte_index    = spr_pkg::BIDX_W'(bidx);
        request_q.insert(request_q.size(), rq);
        if (kind != REQ_UNUSED)
            g_count++;
        if (kind == spr_pkg::REQ_START && !g_open
            && len + spr_pkg::ENTRY_BYTES <= g_free) begin
            if (len == 0) begin
                g_free -= spr_pkg::ENTRY_BYTES;
                g_lens.insert(g_lens.size(), 0);
            end else begin
                g_open = 1;
                g_left = len;
                g_len  = len;
            end
        end else if (kind == spr_pkg::REQ_DATA && g_open) begin
            g_left--;
            if (g_left == 0) begin
                g_free -= g_len + spr_pkg::ENTRY_BYTES;
                g_lens.insert(g_lens.size(), g_len);
                g_open = 0;
            end
        end
    endtask

    task automatic gen_read();
        int slot, bidx;
        if (g_lens.size() != 0 && $urandom_range(0, 4) != 0)
            slot = $urandom_range(0, g_lens.size() - 1);
        else
            slot = $urandom_range(0, 1023);
        if (slot < g_lens.size() && g_lens[slot] != 0 && $urandom_range(0, 3) != 0)
            bidx = $urandom_range(0, g_lens[slot] - 1);
        else
            bidx = $urandom_range(0, 4095);
        push_req(spr_pkg::REQ_READ, $urandom_range(0, 8191), $urandom_range(0, 255),
                 slot, bidx);
    endtask

    task automatic gen_oversized();
        int lo;
        lo = (g_free > 3) ? g_free - 3 : 0;
        push_req(spr_pkg::REQ_START, $urandom_range(lo, 8191), $urandom_range(0, 255),
                 $urandom_range(0, 1023), $urandom_range(0, 4095));
    endtask

    task automatic gen_record(input int len);
        push_req(spr_pkg::REQ_START, len, $urandom_range(0, 255), $urandom_range(0, 1023),
                 $urandom_range(0, 4095));
        while (g_open) begin
            if ($urandom_range(0, 7) == 0)
                gen_read();
            else if ($urandom_range(0, 49) == 0)
                push_req(spr_pkg::REQ_START, $urandom_range(0, 8191), 0, 0, 0);
            else if ($urandom_range(0, 49) == 0)
                push_req(REQ_UNUSED, $urandom_range(0, 8191), $urandom_range(0, 255),
                         $urandom_range(0, 1023), $urandom_range(0, 4095));
            else
                push_req(spr_pkg::REQ_DATA, $urandom_range(0, 8191), $urandom_range(0, 255),
                         $urandom_range(0, 1023), $urandom_range(0, 4095));
        end
    endtask

    initial begin
        int pick, len;

        // directed
        push_req(spr_pkg::REQ_READ, 0, 0, 0, 0);
        push_req(spr_pkg::REQ_DATA, 0, 8'hff, 0, 0);
        push_req(REQ_UNUSED, 8191, 8'hff, 1023, 4095);
        push_req(spr_pkg::REQ_START, spr_pkg::PAGE_BYTES, 0, 0, 0);
        push_req(spr_pkg::REQ_START, 8191, 0, 0, 0);
        push_req(spr_pkg::REQ_START,
                 spr_pkg::PAGE_BYTES - spr_pkg::HDR_BYTES - spr_pkg::ENTRY_BYTES + 1, 0, 0, 0);
        push_req(spr_pkg::REQ_START, 0, 0, 0, 0);
        push_req(spr_pkg::REQ_READ, 0, 0, 0, 0);
        push_req(spr_pkg::REQ_START, 3, 0, 0, 0);
        push_req(spr_pkg::REQ_START, 1, 0, 0, 0);
        push_req(spr_pkg::REQ_READ, 0, 0, 0, 4095);
        push_req(spr_pkg::REQ_DATA, 0, 8'h00, 0, 0);
        push_req(spr_pkg::REQ_DATA, 0, 8'hff, 0, 0);
        push_req(spr_pkg::REQ_DATA, 0, 8'ha5, 0, 0);
        push_req(spr_pkg::REQ_READ, 0, 0, 1, 2);
        push_req(spr_pkg::REQ_READ, 0, 0, 1, 0);
        push_req(spr_pkg::REQ_READ, 0, 0, 1, 4095);
        push_req(spr_pkg::REQ_READ, 0, 0, 1023, 0);
        push_req(spr_pkg::REQ_READ, 0, 0, 2, 0);
        push_req(spr_pkg::REQ_START, 1, 0, 0, 0);
        push_req(spr_pkg::REQ_DATA, 0, 8'h5a, 0, 0);
        push_req(spr_pkg::REQ_READ, 0, 0, 2, 0);

        // random sequences, reads and noise
        while (g_count < RAND_ITEMS && g_free >= 64) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    len = 0;
                else if (pick < 85)
                    len = $urandom_range(1, 12);
                else if (pick < 95)
                    len = $urandom_range(13, 64);
                else
                    len = $urandom_range(65, 300);
                gen_record(len);
            end else if (pick < 85) begin
                gen_read();
            end else if (pick < 90) begin
                push_req(spr_pkg::REQ_DATA, $urandom_range(0, 8191), $urandom_range(0, 255),
                         $urandom_range(0, 1023), $urandom_range(0, 4095));
            end else if (pick < 95) begin
                push_req(REQ_UNUSED, $urandom_range(0, 8191), $urandom_range(0, 255),
                         $urandom_range(0, 1023), $urandom_range(0, 4095));
            end else begin
                gen_oversized();
            end
        end

        // fill the page exactly
        if (g_free % spr_pkg::ENTRY_BYTES != 0
            && g_free >= spr_pkg::ENTRY_BYTES + g_free % spr_pkg::ENTRY_BYTES)
            gen_record(g_free % spr_pkg::ENTRY_BYTES);
        while (g_free >= spr_pkg::ENTRY_BYTES) begin
            if ($urandom_range(0, 9) == 0)
                gen_read();
            else
                push_req(spr_pkg::REQ_START, 0, $urandom_range(0, 255),
                         $urandom_range(0, 1023), $urandom_range(0, 4095));
        end

        // full page
        repeat (TAIL_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick < 5)
                gen_read();
            else if (pick < 7)
                push_req(spr_pkg::REQ_START,
                         $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8191),
                         $urandom_range(0, 255), 0, 0);
            else if (pick < 9)
                push_req(spr_pkg::REQ_DATA, 0, $urandom_range(0, 255), 0, 0);
            else
                push_req(REQ_UNUSED, 0, 0, 0, 0);
        end
    end

    // ---------------------------------------------------------------- driver
    always @(posedge i_clk) begin
        t_request rq;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            gap_left     <= 0;
        end else if (!req_ch.valid || req_ch.ready) begin
            if (gap_left != 0) begin
                req_ch.valid <= 1'b0;
                gap_left     <= gap_left - 1;
            end else if (request_q.size() != 0) begin
                rq = request_q.pop_front();
                req_ch.valid         <= 1'b1;
                req_ch.req_type      <= rq.req_type;
                req_ch.rec_len       <= rq.rec_len;
                req_ch.data_byte     <= rq.data_byte;
                req_ch.slot_index    <= rq.slot_index;
                req_ch.byte_index    <= rq.byte_index;
                if (request_q.size() >= QUIET_ITEMS && $urandom_range(0, 3) == 0)
                    gap_left <= $urandom_range(1, 4);
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            hold_left    <= 0;
        end else if (hold_left != 0) begin
            res_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (request_q.size() >= QUIET_ITEMS && $urandom_range(0, 5) == 0) begin
            res_ch.ready <= 1'b0;
            hold_left    <= $urandom_range(0, 3);
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    // --------------------------------------------------------------- monitor
    always @(posedge i_clk) begin
        t_request         rq;
        spr_pkg::t_result want;
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready) begin
                rq.req_type      = req_ch.req_type;
                rq.rec_len       = req_ch.rec_len;
                rq.data_byte     = req_ch.data_byte;
                rq.slot_index    = req_ch.slot_index;
                rq.byte_index    = req_ch.byte_index;
                page_apply(rq);
            end
            if (res_ch.valid && res_ch.ready) begin
                if (reply_q.size() == 0) begin
                    report_error("result transfer with nothing expected");
                end else begin
                    want = reply_q.pop_front();
                    check_field("status", 16'(res_ch.status), 16'(want.status));
                    check_field("slot_id", 16'(res_ch.slot_id), 16'(want.slot_id));
                    check_field("rec_off", 16'(res_ch.rec_off), 16'(want.rec_off));
                    check_field("record_size", 16'(res_ch.record_size),
                                16'(want.record_size));
                    check_field("data_out", 16'(res_ch.data_out), 16'(want.data_out));
                    check_field("slot_total", 16'(res_ch.slot_total), 16'(want.slot_total));
                    check_field("free_bytes", 16'(res_ch.free_bytes), 16'(want.free_bytes));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        @(posedge i_rst_n);
        @(negedge i_clk);
        while (request_q.size() != 0 || req_ch.valid || reply_q.size() != 0)
            @(negedge i_clk);
        repeat (END_CYCLES) @(negedge i_clk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
